// ===== sv/kelmt_pkg.sv =====
// Shared types and constants of the key event listener match table.
// Holds the table geometry, operation and status codes, and the entry and payload structs.
// No dependencies.
package kelmt_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(RESULT_LIMIT);

   // operation codes carried in the mode field
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_EVENT  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EXISTS = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // bit positions within the subscription flags
   localparam int FLAG_RELEASED  = 0;
   localparam int FLAG_PRESSED   = 1;
   localparam int FLAG_KEYCODE   = 2;
   localparam int FLAG_CHARACTER = 3;

   typedef struct packed {
      logic [15:0] thread_id;
      logic [3:0]  flags;
      logic [7:0]  key;
      logic [7:0]  modifier;
   } entry_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] thread_id;
      logic [3:0]  want_flags;
      logic [7:0]  want_key;
      logic [7:0]  modifier_bits;
      logic        is_release;
      logic [7:0]  event_keycode;
      logic [7:0]  event_char;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [15:0] hit_thread;
      logic        last;
   } rsp_type;

endpackage

// ===== sv/kelmt_if.sv =====
// Valid/ready channel interfaces of the key event listener match table.
// Depends on kelmt_pkg for the payload structs.
interface kelmt_req_if;
   logic              valid;
   logic              ready;
   kelmt_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface kelmt_rsp_if;
   logic              valid;
   logic              ready;
   kelmt_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/key_event_listener_match_table_unit.sv =====
// Operation: a request transfer is followed by a scan of one table slot per cycle, held
// while a hit waits on a busy output register; the final result is then registered and
// transfers when rsp is ready. A new request is taken only in idle, after the final
// result of the last one is registered; the single slot comparator and the one read port
// of the entry store make the scan go slot by slot. A key event streams its hits during
// the scan. Reset is synchronous, active high: the table empties at once (valid bits
// cleared), the sequencer returns to idle and any held result is dropped.
module key_event_listener_match_table_unit (
   input  logic               clock,
   input  logic               reset,
   kelmt_req_if.sink          req_chan,
   kelmt_rsp_if.source        rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int IDX_W = kelmt_pkg::IDX_W;
   localparam int CNT_W = kelmt_pkg::CNT_W;

   // sequencer and captured request
   state_type                          state_ff, state_in;
   kelmt_pkg::req_type                 req_ff;
   logic [IDX_W-1:0]                   scan_ff, scan_in;

   // entry store: one read port, registered read data
   kelmt_pkg::entry_type               mem [kelmt_pkg::TABLE_DEPTH];
   kelmt_pkg::entry_type               rd_ff;
   logic [IDX_W-1:0]                   rd_addr;
   logic                               mem_we;
   logic [kelmt_pkg::TABLE_DEPTH-1:0]  valid_ff;

   // scan results
   logic                               same_found_ff;
   logic [IDX_W-1:0]                   same_idx_ff;
   logic                               free_found_ff;
   logic [IDX_W-1:0]                   free_idx_ff;
   logic                               pend_vld_ff;
   logic [15:0]                        pend_thread_ff;
   logic [CNT_W-1:0]                   cnt_ff;

   // output register
   logic                               rsp_valid_ff;
   kelmt_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   // datapath terms
   kelmt_pkg::entry_type               probe;
   logic                               slot_v;
   logic                               is_same;
   logic                               edge_ok, key_ok, ev_hit;
   logic                               out_free, stall, adv;
   logic                               emit_mid, emit_end, accept;
   logic                               add_ok;

   // The request's own entry, compared against each slot for add and remove.
   assign probe = '{thread_id: req_ff.thread_id, flags: req_ff.want_flags,
                    key: req_ff.want_key, modifier: req_ff.modifier_bits};

   assign slot_v  = valid_ff[scan_ff];
   assign is_same = slot_v && (rd_ff == probe);

   // Key event test on the slot under the scan pointer.
   assign edge_ok = (rd_ff.flags[kelmt_pkg::FLAG_RELEASED] && req_ff.is_release) ||
                    (rd_ff.flags[kelmt_pkg::FLAG_PRESSED] && !req_ff.is_release);
   assign key_ok  = (rd_ff.flags[kelmt_pkg::FLAG_KEYCODE] &&
                     rd_ff.key == req_ff.event_keycode) ||
                    (rd_ff.flags[kelmt_pkg::FLAG_CHARACTER] &&
                     rd_ff.key == req_ff.event_char);
   assign ev_hit  = (state_ff == ST_SCAN) && slot_v &&
                    (req_ff.mode == kelmt_pkg::MODE_EVENT) &&
                    (rd_ff.modifier == req_ff.modifier_bits) &&
                    edge_ok && key_ok && (cnt_ff != kelmt_pkg::CNT_LIMIT);

   // A hit is held back in the hold register so the final one can carry the last mark.
   // Hold the scan when a held hit must move out but the output register is busy.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign stall    = ev_hit && pend_vld_ff && !out_free;
   assign adv      = (state_ff == ST_SCAN) && !stall;
   assign emit_mid = ev_hit && pend_vld_ff && out_free;
   assign emit_end = (state_ff == ST_DONE) && out_free;
   assign accept   = (state_ff == ST_IDLE) && req_chan.valid;

   assign add_ok = (req_ff.mode == kelmt_pkg::MODE_ADD) && !same_found_ff && free_found_ff;
   assign mem_we = emit_end && add_ok;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Read address: start at slot zero on a transfer, advance with the scan, hold on a stall.
   always_comb begin
      if (accept) begin
         rd_addr = '0;
      end else if (adv && scan_ff != kelmt_pkg::LAST_SLOT) begin
         rd_addr = scan_ff + 1'b1;
      end else begin
         rd_addr = scan_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            if (adv) begin
               if (scan_ff == kelmt_pkg::LAST_SLOT) begin
                  state_in = ST_DONE;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (emit_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result formed for the output register.
   always_comb begin
      rsp_data_in = '{status: kelmt_pkg::STATUS_OK, hit: 1'b0, hit_thread: 16'd0, last: 1'b1};
      if (emit_mid) begin
         rsp_data_in.hit        = 1'b1;
         rsp_data_in.hit_thread = pend_thread_ff;
         rsp_data_in.last       = 1'b0;
      end else if (req_ff.mode == kelmt_pkg::MODE_ADD) begin
         if (same_found_ff) begin
            rsp_data_in.status = kelmt_pkg::STATUS_EXISTS;
         end else if (!free_found_ff) begin
            rsp_data_in.status = kelmt_pkg::STATUS_FULL;
         end
      end else if (req_ff.mode == kelmt_pkg::MODE_EVENT && pend_vld_ff) begin
         rsp_data_in.hit        = 1'b1;
         rsp_data_in.hit_thread = pend_thread_ff;
      end
   end

   // Entry store.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= probe;
      end
      rd_ff <= mem[rd_addr];
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_chan.data;
      end
      if (emit_mid || emit_end) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (adv && is_same && !same_found_ff) begin
         same_idx_ff <= scan_ff;
      end
      if (adv && !slot_v && !free_found_ff) begin
         free_idx_ff <= scan_ff;
      end
      if (ev_hit && (!pend_vld_ff || out_free)) begin
         pend_thread_ff <= rd_ff.thread_id;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         valid_ff      <= '0;
         same_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         pend_vld_ff   <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;

         if (accept) begin
            same_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
            pend_vld_ff   <= 1'b0;
            cnt_ff        <= '0;
         end else begin
            if (adv && is_same) begin
               same_found_ff <= 1'b1;
            end
            if (adv && !slot_v) begin
               free_found_ff <= 1'b1;
            end
            // take a new hit into the hold stage once the previous one has moved on
            if (ev_hit && (!pend_vld_ff || out_free)) begin
               pend_vld_ff <= 1'b1;
               cnt_ff      <= cnt_ff + 1'b1;
            end
         end

         // commit table updates with the final transfer of the request
         if (emit_end) begin
            if (add_ok) begin
               valid_ff[free_idx_ff] <= 1'b1;
            end else if (req_ff.mode == kelmt_pkg::MODE_REMOVE && same_found_ff) begin
               valid_ff[same_idx_ff] <= 1'b0;
            end
         end

         if (emit_mid || emit_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // A stalled scan always has a held hit and a full output register behind it.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !adv) |-> (pend_vld_ff && rsp_valid_ff))
      else $error("scan held without a pending hit and busy output");

   // Only a key event streams results without the last mark.
   a_mid_only_event: assert property (@(posedge clock) disable iff (reset)
      (emit_mid) |-> (state_ff == ST_SCAN && req_ff.mode == kelmt_pkg::MODE_EVENT))
      else $error("non-final result outside a key event scan");

   // A successful add occupies exactly one more slot.
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (emit_end && add_ok) |=>
         ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("add did not occupy exactly one slot");

   // A hit result is always reported with an ok status.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.hit) |-> (rsp_data_ff.status == kelmt_pkg::STATUS_OK))
      else $error("hit result with non-ok status");

endmodule

// ===== bench/key_event_listener_match_table_unit_tb.sv =====
// Testbench of key_event_listener_match_table_unit: adds, removes, key events and no-ops.
// Depends on kelmt_pkg and the kelmt_req_if / kelmt_rsp_if channel interfaces.
// A subscription scoreboard predicts every result and checks them in order.
`timescale 1ns / 1ps

module key_event_listener_match_table_unit_tb;

   localparam int MAX_WAIT     = 13;
   localparam int RANDOM_ITEMS = 220;

   // Mirror of the subscription table; turns each accepted request into the
   // list of results the block owes for it, then checks them as they arrive.
   class subscription_scoreboard;
      kelmt_pkg::entry_type slots[kelmt_pkg::TABLE_DEPTH];
      bit                   occupied[kelmt_pkg::TABLE_DEPTH];
      kelmt_pkg::rsp_type   due_results[$];
      int unsigned          errors;

      function int find_slot(kelmt_pkg::entry_type e);
         for (int i = 0; i < kelmt_pkg::TABLE_DEPTH; i++) begin
            if (occupied[i] && slots[i] == e) return i;
         end
         return -1;
      endfunction

      function void owe(logic [1:0] status, logic hit, logic [15:0] thread, logic last);
         kelmt_pkg::rsp_type r;
         r.status     = status;
         r.hit        = hit;
         r.hit_thread = thread;
         r.last       = last;
         due_results.push_back(r);
      endfunction

      function void note_request(kelmt_pkg::req_type q);
         kelmt_pkg::entry_type e;
         kelmt_pkg::rsp_type   hits[$];
         kelmt_pkg::rsp_type   h;
         int                   idx;
         bit                   edge_ok;
         bit                   key_ok;
         e.thread_id = q.thread_id;
         e.flags     = q.want_flags;
         e.key       = q.want_key;
         e.modifier  = q.modifier_bits;
         case (q.mode)
            kelmt_pkg::MODE_ADD: begin
               idx = find_slot(e);
               if (idx >= 0) begin
                  owe(kelmt_pkg::STATUS_EXISTS, 1'b0, 16'h0, 1'b1);
               end else begin
                  idx = -1;
                  for (int i = 0; i < kelmt_pkg::TABLE_DEPTH; i++) begin
                     if (!occupied[i] && idx < 0) idx = i;
                  end
                  if (idx >= 0) begin
                     occupied[idx] = 1'b1;
                     slots[idx]    = e;
                     owe(kelmt_pkg::STATUS_OK, 1'b0, 16'h0, 1'b1);
                  end else begin
                     owe(kelmt_pkg::STATUS_FULL, 1'b0, 16'h0, 1'b1);
                  end
               end
            end
            kelmt_pkg::MODE_REMOVE: begin
               idx = find_slot(e);
               if (idx >= 0) occupied[idx] = 1'b0;
               owe(kelmt_pkg::STATUS_OK, 1'b0, 16'h0, 1'b1);
            end
            kelmt_pkg::MODE_EVENT: begin
               for (int i = 0; i < kelmt_pkg::TABLE_DEPTH; i++) begin
                  if (occupied[i] && hits.size() < kelmt_pkg::RESULT_LIMIT &&
                      slots[i].modifier == q.modifier_bits) begin
                     edge_ok = (slots[i].flags[kelmt_pkg::FLAG_RELEASED] && q.is_release) ||
                               (slots[i].flags[kelmt_pkg::FLAG_PRESSED] && !q.is_release);
                     key_ok  = (slots[i].flags[kelmt_pkg::FLAG_KEYCODE] &&
                                slots[i].key == q.event_keycode) ||
                               (slots[i].flags[kelmt_pkg::FLAG_CHARACTER] &&
                                slots[i].key == q.event_char);
                     if (edge_ok && key_ok) begin
                        h.status     = kelmt_pkg::STATUS_OK;
                        h.hit        = 1'b1;
                        h.hit_thread = slots[i].thread_id;
                        h.last       = 1'b0;
                        hits.push_back(h);
                     end
                  end
               end
               if (hits.size() == 0) begin
                  owe(kelmt_pkg::STATUS_OK, 1'b0, 16'h0, 1'b1);
               end else begin
                  hits[hits.size()-1].last = 1'b1;
                  foreach (hits[k]) due_results.push_back(hits[k]);
               end
            end
            default: owe(kelmt_pkg::STATUS_OK, 1'b0, 16'h0, 1'b1);
         endcase
      endfunction

      function void check_result(kelmt_pkg::rsp_type got);
         kelmt_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing due: status %0d hit %0b thread %h last %0b",
                     $time, got.status, got.hit, got.hit_thread, got.last);
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status || got.hit !== want.hit ||
             got.hit_thread !== want.hit_thread || got.last !== want.last) begin
            errors++;
            $display("%0t: expected %0d %0b %h %0b, got %0d %0b %h %0b (status hit thread last)",
                     $time, want.status, want.hit, want.hit_thread, want.last,
                     got.status, got.hit, got.hit_thread, got.last);
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   no_idle;

   kelmt_req_if req_chan ();
   kelmt_rsp_if rsp_chan ();

   subscription_scoreboard sb = new;

   key_event_listener_match_table_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 2 ns period
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Draw the idle cycles ahead of one transfer; during a stretch of back-to-back
   // traffic both sides skip idling altogether.
   function int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function kelmt_pkg::req_type build_request(logic [1:0] mode, logic [15:0] tid,
                                              logic [3:0] flags, logic [7:0] key,
                                              logic [7:0] modifier, logic rel,
                                              logic [7:0] keycode, logic [7:0] ch);
      kelmt_pkg::req_type q;
      q.mode          = mode;
      q.thread_id     = tid;
      q.want_flags    = flags;
      q.want_key      = key;
      q.modifier_bits = modifier;
      q.is_release    = rel;
      q.event_keycode = keycode;
      q.event_char    = ch;
      return q;
   endfunction

   // Idle for a drawn number of cycles, then present the request and hold it
   // until the transfer; valid stays high so a following request can go straight on.
   task automatic send_request(kelmt_pkg::req_type q);
      int gap;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.data  <= q;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(q);
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
   endtask

   // Drop valid, then hold off new requests until every result owed so far has been taken.
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Result side: stall for a drawn number of cycles, then accept one transfer.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         repeat (stall) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         sb.check_result(rsp_chan.data);
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [3:0]           full_flags[6];
      kelmt_pkg::entry_type added[$];
      kelmt_pkg::entry_type pick;
      logic [7:0]           key_pool[4];
      logic [7:0]           mod_pool[3];
      kelmt_pkg::req_type   q;
      int                   roll;
      int                   idx;

      full_flags = '{4'b0110, 4'b1010, 4'b1110, 4'b0111, 4'b1011, 4'b1111};
      key_pool   = '{8'h00, 8'h41, 8'h7F, 8'hFF};
      mod_pool   = '{8'h00, 8'h01, 8'h80};

      reset          = 1'b1;
      no_idle        = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed part: empty table, extremes, fill to capacity, full scan, edges.
      send_request(build_request(kelmt_pkg::MODE_EVENT, 16'h0, 4'h0, 8'h00, 8'hFF, 1'b0,
                                 8'hFF, 8'hFF));
      send_request(build_request(kelmt_pkg::MODE_REMOVE, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, 1'b1,
                                 8'h00, 8'h00));
      send_request(build_request(kelmt_pkg::MODE_NOP, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, 1'b1,
                                 8'hFF, 8'hFF));
      // every entry listens for key 0xFF pressed, by keycode, character or both
      for (int i = 0; i < kelmt_pkg::TABLE_DEPTH; i++)
         send_request(build_request(kelmt_pkg::MODE_ADD, 16'(i * 16'h1111), full_flags[i % 6],
                                    8'hFF, 8'h00, 1'b0, 8'h00, 8'h00));
      // identical entry, then a new one with no free slot
      send_request(build_request(kelmt_pkg::MODE_ADD, 16'h3333, full_flags[3], 8'hFF, 8'h00,
                                 1'b0, 8'h00, 8'h00));
      send_request(build_request(kelmt_pkg::MODE_ADD, 16'h1234, 4'b0110, 8'h00, 8'h00, 1'b0,
                                 8'h00, 8'h00));
      // press matching all sixteen: result limit reached, last on the sixteenth
      send_request(build_request(kelmt_pkg::MODE_EVENT, 16'h0, 4'h0, 8'h00, 8'h00, 1'b0,
                                 8'hFF, 8'hFF));
      // release by character only: entries with released and character flags
      send_request(build_request(kelmt_pkg::MODE_EVENT, 16'h0, 4'h0, 8'h00, 8'h00, 1'b1,
                                 8'h00, 8'hFF));
      send_request(build_request(kelmt_pkg::MODE_REMOVE, 16'h5555, full_flags[5], 8'hFF,
                                 8'h00, 1'b0, 8'h00, 8'h00));
      // modifier mismatch gives the empty result
      send_request(build_request(kelmt_pkg::MODE_EVENT, 16'h0, 4'h0, 8'h00, 8'h01, 1'b0,
                                 8'hFF, 8'hFF));
      drain();

      // Random part: mostly drawn from small pools so that events hit and adds collide.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         q = build_request(2'($urandom_range(0, 3)), 16'($urandom()), 4'($urandom()),
                           8'($urandom()), 8'($urandom()), 1'($urandom()),
                           8'($urandom()), 8'($urandom()));
         roll = $urandom_range(0, 99);
         if (roll < 90) begin
            if (roll < 38) q.mode = kelmt_pkg::MODE_ADD;
            else if (roll < 60) q.mode = kelmt_pkg::MODE_REMOVE;
            else if (roll < 86) q.mode = kelmt_pkg::MODE_EVENT;
            else q.mode = kelmt_pkg::MODE_NOP;
            q.thread_id     = 16'($urandom_range(0, 7));
            q.want_key      = key_pool[$urandom_range(0, 3)];
            q.modifier_bits = mod_pool[$urandom_range(0, 2)];
            q.event_keycode = key_pool[$urandom_range(0, 3)];
            q.event_char    = key_pool[$urandom_range(0, 3)];
         end
         // replay an earlier subscription for removes and some re-adds
         if (added.size() != 0 && (q.mode == kelmt_pkg::MODE_REMOVE ||
                                   (q.mode == kelmt_pkg::MODE_ADD &&
                                    $urandom_range(0, 4) == 0))) begin
            idx             = $urandom_range(0, added.size() - 1);
            pick            = added[idx];
            q.thread_id     = pick.thread_id;
            q.want_flags    = pick.flags;
            q.want_key      = pick.key;
            q.modifier_bits = pick.modifier;
            if (q.mode == kelmt_pkg::MODE_REMOVE) added.delete(idx);
         end
         if (q.mode == kelmt_pkg::MODE_ADD) begin
            pick.thread_id = q.thread_id;
            pick.flags     = q.want_flags;
            pick.key       = q.want_key;
            pick.modifier  = q.modifier_bits;
            added.push_back(pick);
            if (added.size() > 32) added.delete(0);
         end
         send_request(q);
         if ($urandom_range(0, 39) == 0) drain();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      drain();
      repeat (kelmt_pkg::TABLE_DEPTH + 8) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
